// ===== rtl/smc_pkg.sv =====
// Shared constants, types and the sine table for the sine-swept chorus core.
package smc_pkg;

  // Delay line geometry
  localparam int MAX_LINE = 2048;
  localparam int LINE_AW  = $clog2(MAX_LINE);
  localparam int LEN_W    = LINE_AW + 1;

  // Field and register widths
  localparam int SAMPLE_W  = 16;
  localparam int WET_W     = 7;
  localparam int STEP_W    = 20;
  localparam int PHASE_W   = 24;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [WET_W-1:0]   WET_RESET  = 7'd50;
  localparam logic [LEN_W-1:0]   LEN_RESET  = LEN_W'(1102);
  localparam logic [STEP_W-1:0]  STEP_RESET = 20'd30;
  localparam logic [LEN_W-1:0]   LEN_MIN    = LEN_W'(2);
  localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(MAX_LINE);
  localparam int                 WET_FULL   = 100;

  // Sine oscillator
  localparam int SINE_ENTRIES = 1024;
  localparam int SIN_AW       = $clog2(SINE_ENTRIES);
  localparam int QTR_ENTRIES  = SINE_ENTRIES / 4;
  localparam int QTR_AW       = SIN_AW - 2;
  localparam int MAG_W        = SAMPLE_W - 1;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Shift-add datapath
  localparam int FRAC_W     = 8;
  localparam int MIX_SHIFT  = 9;
  localparam int MCAND_W    = SAMPLE_W + MIX_SHIFT;
  localparam int ACC_W      = 33;
  localparam int PROD_W     = SAMPLE_W + LINE_AW;
  localparam int OFF_W      = PROD_W - FRAC_W;
  localparam int MPL_W      = (LINE_AW > FRAC_W) ? LINE_AW : FRAC_W;
  localparam int STEP_CNT_W = $clog2(MPL_W);
  // (25600 + 51200 * 65536) / 128: rounding term plus a bias that keeps the
  // mix positive, preloaded before the seven mix steps shift it up by 2^7
  localparam logic [ACC_W-1:0] MIX_BIAS = 33'd26214600;

  // Divider
  localparam int DVD_W  = ACC_W - MIX_SHIFT;
  localparam int QUOT_W = SAMPLE_W;
  localparam int REM_W  = $clog2(WET_FULL);
  localparam int DCNT_W = $clog2(DVD_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WET_PERCENT = 2'd0,
    REG_LINE_LENGTH = 2'd1,
    REG_LFO_STEP    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_OFF,
    S_POS,
    S_RDA,
    S_RDB,
    S_LDB,
    S_MUL2,
    S_LDMIX,
    S_MIX,
    S_DSTART,
    S_DIV,
    S_OUT
  } smc_state_e;

  typedef struct packed {
    logic                en;
    logic [LINE_AW-1:0]  addr;
    logic [SAMPLE_W-1:0] data;
  } line_wr_t;

  typedef struct packed {
    logic               en;
    logic [LINE_AW-1:0] addr;
  } line_rd_t;

  typedef logic [MAG_W-1:0] qsine_lut_t [QTR_ENTRIES];

  // sin(pi/2 * j / QTR_ENTRIES) in Q1.15, Taylor series in Q30
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (PI_HALF_Q30 * (64'(j) * 64'd4)) / SINE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) begin
      sum = 64'sd32767;
    end
    return sum[MAG_W-1:0];
  endfunction

  function automatic qsine_lut_t build_qsine();
    qsine_lut_t lut;
    for (int j = 0; j < QTR_ENTRIES; j++) begin
      lut[j] = quarter_sine(j);
    end
    return lut;
  endfunction

  localparam qsine_lut_t       QSINE_LUT = build_qsine();
  localparam logic [MAG_W-1:0] SIN_PEAK  = quarter_sine(QTR_ENTRIES);

endpackage

// ===== rtl/smc_line_mem.sv =====
// Circular delay line storage with a fill count standing in for the zero reset.
module smc_line_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  smc_pkg::line_wr_t            wr_i,
  input  smc_pkg::line_rd_t            rd_i,
  output logic [smc_pkg::SAMPLE_W-1:0] rdata_o
);
  import smc_pkg::*;

  logic [SAMPLE_W-1:0] mem_q [MAX_LINE];
  logic [SAMPLE_W-1:0] rdata_q;
  logic                rhit_q;
  // writes only ever extend a prefix [0, fill) of the store
  logic [LEN_W-1:0]    fill_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rhit_q <= 1'b0;
    end else begin
      if (wr_i.en && (LEN_W'(wr_i.addr) == fill_q)) begin
        fill_q <= fill_q + LEN_W'(1);
      end
      if (rd_i.en) begin
        rhit_q <= LEN_W'(rd_i.addr) < fill_q;
      end
    end
  end

  // never-written entries read as the reset value, zero
  assign rdata_o = rhit_q ? rdata_q : '0;

endmodule

// ===== rtl/smc_div.sv =====
// Bit-serial restoring divider by the wet-share full scale (100).
module smc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [smc_pkg::DVD_W-1:0]  dividend_i,
  output logic                       done_o,
  output logic [smc_pkg::QUOT_W-1:0] quot_o
);
  import smc_pkg::*;

  logic [DVD_W-1:0]  dq_q;   // dividend shifts out, quotient shifts in
  logic [REM_W-1:0]  rem_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic [REM_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, dq_q[DVD_W-1]};
  assign ge    = trial >= (REM_W + 1)'(WET_FULL);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DVD_W-2:0], ge};
      rem_q <= ge ? REM_W'(trial - (REM_W + 1)'(WET_FULL)) : trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DCNT_W'(DVD_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DCNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = dq_q[QUOT_W-1:0];

endmodule

// ===== rtl/sine_modulated_chorus_core.sv =====
// Top level of the sine-swept chorus: control, shift-add datapath, I/O.
//
// Chorus core: each accepted sample is written into a circular delay line of
// line_length entries, a 24-bit sine oscillator sets a fractional read offset,
// the two neighboring taps are linearly interpolated, averaged with the dry
// sample and mixed with it by wet_percent. Per sample, the single bit-serial
// shift-add unit forms the offset product (11 bits), the two taps are read one
// after the other through the single read port of the line memory, the same
// unit interpolates (8 bits) and mixes (7 bits), and the bit-serial divider
// produces 24 quotient bits. A new sample is accepted only once the result has
// been loaded into the output register; a finished sample waits there while
// the next one is taken. No clearing pass runs after reset: a fill count
// makes entries never written read as zero. Configuration registers are
// write-only and are to be changed only while no transaction is in flight.
module sine_modulated_chorus_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [smc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [smc_pkg::CFG_W-1:0]           cfg_data_i,
  // input samples
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [smc_pkg::SAMPLE_W-1:0] sample_in_i,
  // output samples
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [smc_pkg::SAMPLE_W-1:0] sample_out_o
);
  import smc_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [WET_W-1:0]  wet_q;
  logic [LEN_W-1:0]  len_q;
  logic [STEP_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wet_q  <= WET_RESET;
      len_q  <= LEN_RESET;
      step_q <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_WET_PERCENT: wet_q  <= cfg_data_i[WET_W-1:0];
        REG_LINE_LENGTH: len_q  <= cfg_data_i[LEN_W-1:0];
        REG_LFO_STEP:    step_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings: length clamped to [2, MAX_LINE], wet share to 100
  logic [LEN_W-1:0] len_eff;
  logic [WET_W-1:0] wet_eff;
  logic [WET_W-1:0] dry_eff;

  always_comb begin
    if (len_q < LEN_MIN) begin
      len_eff = LEN_MIN;
    end else if (len_q > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_q;
    end
  end

  assign wet_eff = (wet_q > WET_W'(WET_FULL)) ? WET_W'(WET_FULL) : wet_q;
  assign dry_eff = WET_W'(WET_FULL) - wet_eff;

  // ---------------------------------------------------------------------
  // Handshake and sequencer
  // ---------------------------------------------------------------------
  smc_state_e         state_q, state_d;
  logic [STEP_CNT_W-1:0] cnt_q;
  logic               in_fire;
  logic               out_load;
  logic               out_valid_q;
  logic               div_start;
  logic               div_done;
  logic [QUOT_W-1:0]  div_quot;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Delay line ports
  line_wr_t            line_wr;
  line_rd_t            line_rd;
  logic [SAMPLE_W-1:0] line_rdata;

  // Datapath registers
  logic [LINE_AW-1:0]      wi_q;       // write position of the next sample
  logic [LINE_AW-1:0]      wi_cur_q;   // write position of this sample
  logic [PHASE_W-1:0]      phase_q;
  logic signed [SAMPLE_W-1:0] dry_q;
  logic signed [SAMPLE_W-1:0] a_q;
  logic [OFF_W-1:0]        off_q;
  logic [LINE_AW-1:0]      pos_q;
  logic [MCAND_W-1:0]      mca_q;
  logic [ACC_W-1:0]        acc_q;
  logic [MPL_W-1:0]        mpl_a_q;
  logic [WET_W-1:0]        mpl_b_q;
  logic [SAMPLE_W-1:0]     out_q;

  // Write index wrap: restart at 0 if the line was shortened under it
  logic [LINE_AW-1:0] wi_eff;
  logic [LEN_W-1:0]   wi_inc;
  logic [LINE_AW-1:0] wi_next;

  assign wi_eff  = (LEN_W'(wi_q) >= len_eff) ? '0 : wi_q;
  assign wi_inc  = LEN_W'(wi_eff) + LEN_W'(1);
  assign wi_next = (wi_inc >= len_eff) ? '0 : wi_inc[LINE_AW-1:0];

  // Sine lookup from the quarter-wave table
  logic [SIN_AW-1:0]   sidx;
  logic [1:0]          quad;
  logic [QTR_AW-1:0]   qj;
  logic [MAG_W-1:0]    mag;
  logic [SAMPLE_W-1:0] sine;
  logic [SAMPLE_W-1:0] sine_ofs;   // sine + 32768, unsigned

  assign sidx = phase_q[PHASE_W-1 -: SIN_AW];
  assign quad = sidx[SIN_AW-1 -: 2];
  assign qj   = sidx[QTR_AW-1:0];

  always_comb begin
    if (!quad[0]) begin
      mag = QSINE_LUT[qj];
    end else if (qj == '0) begin
      mag = SIN_PEAK;
    end else begin
      mag = QSINE_LUT[QTR_AW'(0) - qj];   // quarter read mirrored
    end
  end

  assign sine     = quad[1] ? (SAMPLE_W'(0) - {1'b0, mag}) : {1'b0, mag};
  assign sine_ofs = {~sine[SAMPLE_W-1], sine[SAMPLE_W-2:0]};

  // Shared MSB-first shift-add step: acc = 2*acc + bitA*mcand + bitB*(dry<<9)
  logic [ACC_W-1:0] add_a;
  logic [ACC_W-1:0] add_b;
  logic [ACC_W-1:0] acc_step;
  logic [MCAND_W-1:0] dry_sh;

  assign dry_sh   = {dry_q, MIX_SHIFT'(0)};
  assign add_a    = mpl_a_q[MPL_W-1] ? {{(ACC_W-MCAND_W){mca_q[MCAND_W-1]}}, mca_q} : '0;
  assign add_b    = mpl_b_q[WET_W-1] ? {{(ACC_W-MCAND_W){dry_sh[MCAND_W-1]}}, dry_sh} : '0;
  assign acc_step = {acc_q[ACC_W-2:0], 1'b0} + add_a + add_b;

  // Offset rounding, tap positions
  logic [PROD_W-1:0]  prod_rnd;
  logic [LINE_AW-1:0] tap_int;
  logic [FRAC_W-1:0]  tap_frac;
  logic [LEN_W-1:0]   pos_sum;
  logic [LINE_AW-1:0] pos_d;
  logic [LEN_W-1:0]   pos_inc;
  logic [LINE_AW-1:0] pos2;

  assign prod_rnd = acc_q[PROD_W-1:0] + PROD_W'(128);
  assign tap_int  = off_q[OFF_W-1:FRAC_W];
  assign tap_frac = off_q[FRAC_W-1:0];
  // both terms are below the length, so one conditional subtract wraps
  assign pos_sum  = LEN_W'(wi_cur_q) + LEN_W'(tap_int);
  assign pos_d    = (pos_sum >= len_eff) ? LINE_AW'(pos_sum - len_eff)
                                         : pos_sum[LINE_AW-1:0];
  assign pos_inc  = LEN_W'(pos_q) + LEN_W'(1);
  assign pos2     = (pos_inc >= len_eff) ? '0 : pos_inc[LINE_AW-1:0];

  // Interpolation operands
  logic [SAMPLE_W:0] tap_diff;   // b - a
  logic [SAMPLE_W:0] tap_base;   // a + dry, times 256 after eight steps

  assign tap_diff = {line_rdata[SAMPLE_W-1], line_rdata} - {a_q[SAMPLE_W-1], a_q};
  assign tap_base = {a_q[SAMPLE_W-1], a_q} + {dry_q[SAMPLE_W-1], dry_q};

  // Next state and strobes
  always_comb begin
    state_d   = state_q;
    line_wr   = '0;
    line_rd   = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          line_wr.en   = 1'b1;
          line_wr.addr = wi_eff;
          line_wr.data = sample_in_i;
          state_d      = S_MUL1;
        end
      end
      S_MUL1: begin
        if (cnt_q == '0) begin
          state_d = S_OFF;
        end
      end
      S_OFF: state_d = S_POS;
      S_POS: state_d = S_RDA;
      S_RDA: begin
        line_rd.en   = 1'b1;
        line_rd.addr = pos_q;
        state_d      = S_RDB;
      end
      S_RDB: begin
        line_rd.en   = 1'b1;
        line_rd.addr = pos2;
        state_d      = S_LDB;
      end
      S_LDB: state_d = S_MUL2;
      S_MUL2: begin
        if (cnt_q == '0) begin
          state_d = S_LDMIX;
        end
      end
      S_LDMIX: state_d = S_MIX;
      S_MIX: begin
        if (cnt_q == '0) begin
          state_d = S_DSTART;
        end
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      wi_q        <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cnt_q   <= STEP_CNT_W'(LINE_AW - 1);
            wi_q    <= wi_next;
            phase_q <= phase_q + PHASE_W'(step_q);
          end
        end
        S_MUL1, S_MUL2, S_MIX: cnt_q <= cnt_q - STEP_CNT_W'(1);
        S_LDB:   cnt_q <= STEP_CNT_W'(FRAC_W - 1);
        S_LDMIX: cnt_q <= STEP_CNT_W'(WET_W - 1);
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // offset product: (sine + 32768) * (L - 1)
          dry_q    <= sample_in_i;
          wi_cur_q <= wi_eff;
          mca_q    <= MCAND_W'(sine_ofs);
          acc_q    <= '0;
          mpl_a_q  <= MPL_W'(len_eff[LINE_AW-1:0] - LINE_AW'(1)) << (MPL_W - LINE_AW);
          mpl_b_q  <= '0;
        end
      end
      S_MUL1, S_MUL2, S_MIX: begin
        acc_q   <= acc_step;
        mpl_a_q <= mpl_a_q << 1;
        mpl_b_q <= mpl_b_q << 1;
      end
      S_OFF: off_q <= prod_rnd[PROD_W-1:FRAC_W];
      S_POS: pos_q <= pos_d;
      S_RDB: a_q   <= line_rdata;
      S_LDB: begin
        // wet2 = 256*(a + dry) + (b - a)*frac
        mca_q   <= {{(MCAND_W-SAMPLE_W-1){tap_diff[SAMPLE_W]}}, tap_diff};
        acc_q   <= {{(ACC_W-SAMPLE_W-1){tap_base[SAMPLE_W]}}, tap_base};
        mpl_a_q <= MPL_W'(tap_frac) << (MPL_W - FRAC_W);
        mpl_b_q <= '0;
      end
      S_LDMIX: begin
        // wet2*p + 512*dry*(100 - p) + rounding and positive bias
        mca_q   <= acc_q[MCAND_W-1:0];
        acc_q   <= MIX_BIAS;
        mpl_a_q <= MPL_W'(wet_eff) << (MPL_W - WET_W);
        mpl_b_q <= dry_eff;
      end
      default: ;
    endcase
    if (out_load) begin
      out_q <= div_quot;
    end
  end

  // ---------------------------------------------------------------------
  // Delay line and divider
  // ---------------------------------------------------------------------
  smc_line_mem u_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (line_wr),
    .rd_i    (line_rd),
    .rdata_o (line_rdata)
  );

  // floor(acc / 51200) = floor(floor(acc / 512) / 100); the bias of 65536
  // output units drops out in the low 16 quotient bits
  smc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q[ACC_W-1:MIX_SHIFT]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_tap_a_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDA) |-> (LEN_W'(pos_q) < len_eff))
    else $error("first tap position outside the active line");

  a_tap_b_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDB) |-> (LEN_W'(pos2) < len_eff))
    else $error("second tap position outside the active line");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("new transaction taken while one is in flight");

  a_out_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ready_i))
    else $error("output sample dropped without a transaction");

  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_ready_i) |=> (state_q == S_OUT))
    else $error("result left while the output register was full");

endmodule

// ===== sim/sine_modulated_chorus_core_test.sv =====
// Self-checking testbench for the sine-swept chorus core: directed, random and stalled traffic.
`timescale 1ns / 1ps

// Tracks the chorus state on the side and checks each output transaction in order.
class chorus_scoreboard;
  logic signed [15:0] delay_mem [2048];
  int                 sine_q15 [1024];
  int unsigned        wr_idx;
  logic [23:0]        phase;
  logic [6:0]         wet_pct;
  logic [11:0]        line_len;
  logic [19:0]        lfo_inc;
  logic signed [15:0] expected_out [$];
  int                 mismatches;

  function new();
    longint unsigned t;
    longint unsigned q;
    longint unsigned rem;
    int              v;
    foreach (delay_mem[i]) begin
      delay_mem[i] = '0;
    end
    wr_idx     = 0;
    phase      = '0;
    wet_pct    = 7'd50;
    line_len   = 12'd1102;
    lfo_inc    = 20'd30;
    mismatches = 0;
    // full-wave table folded from one quarter
    for (int i = 0; i < 1024; i++) begin
      t   = longint'(i) * 4;
      q   = t / 1024;
      rem = t % 1024;
      if (q == 0 || q == 2) begin
        v = quarter_wave(rem);
      end else begin
        v = quarter_wave(1024 - rem);
      end
      sine_q15[i] = (q >= 2) ? -v : v;
    end
  endfunction

  // sin(pi/2 * rem/1024) in Q1.15, Taylor series evaluated in Q30
  function int quarter_wave(longint unsigned rem);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (64'd1686629713 * rem) / 64'd1024;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum -= longint'(term);
      end else begin
        sum += longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) begin
      sum = 32767;
    end
    return int'(sum);
  endfunction

  function void write_reg(logic [1:0] idx, logic [19:0] data);
    case (idx)
      smc_pkg::REG_WET_PERCENT: wet_pct  = data[6:0];
      smc_pkg::REG_LINE_LENGTH: line_len = data[11:0];
      smc_pkg::REG_LFO_STEP:    lfo_inc  = data;
      default: ;  // unmapped index does nothing
    endcase
  endfunction

  // One sample through the delay line, the interpolated tap and the wet/dry mix.
  function logic signed [15:0] mix_sample(logic signed [15:0] dry);
    int unsigned len;
    int unsigned pct;
    int unsigned off;
    int unsigned frac;
    int unsigned pos;
    int unsigned pos2;
    longint      s;
    longint      a;
    longint      b;
    longint      wet2;
    longint      num;
    longint      res;
    len = line_len;
    if (len < 2) begin
      len = 2;
    end
    if (len > 2048) begin
      len = 2048;
    end
    pct = (wet_pct > 100) ? 100 : wet_pct;
    // a shortened line pulls the write pointer back to the start
    if (wr_idx >= len) begin
      wr_idx = 0;
    end
    delay_mem[wr_idx] = dry;
    s    = sine_q15[phase[23:14]];
    off  = int'(((s + 32768) * longint'(len - 1) + 128) >>> 8);
    frac = off % 256;
    pos  = (wr_idx + (off >> 8)) % len;
    pos2 = (pos + 1 >= len) ? 0 : pos + 1;
    a    = delay_mem[pos];
    b    = delay_mem[pos2];
    wet2 = a * longint'(256 - frac) + b * longint'(frac) + 256 * longint'(dry);
    num  = wet2 * longint'(pct) + 512 * longint'(dry) * longint'(100 - pct) + 25600;
    // floor division: ties already pushed toward plus infinity by the offset
    res  = num / 51200;
    if (num % 51200 != 0 && num < 0) begin
      res -= 1;
    end
    if (res > 32767) begin
      res = 32767;
    end
    if (res < -32768) begin
      res = -32768;
    end
    wr_idx++;
    if (wr_idx >= len) begin
      wr_idx = 0;
    end
    phase = phase + 24'(lfo_inc);
    return res[15:0];
  endfunction

  function void note_sample(logic signed [15:0] dry);
    expected_out.push_back(mix_sample(dry));
  endfunction

  function void check_sample(logic signed [15:0] actual);
    logic signed [15:0] want;
    if (expected_out.size() == 0) begin
      mismatches++;
      $display("%0t: sample_out expected none, actual %0d", $time, actual);
    end else begin
      want = expected_out.pop_front();
      if (actual !== want) begin
        mismatches++;
        $display("%0t: sample_out expected %0d, actual %0d", $time, want, actual);
      end
    end
  endfunction
endclass

module sine_modulated_chorus_core_test;

  // index 3 is not mapped to any register
  localparam logic [smc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [smc_pkg::CFG_IDX_W-1:0]       cfg_idx_i;
  logic [smc_pkg::CFG_W-1:0]           cfg_data_i;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic signed [smc_pkg::SAMPLE_W-1:0] sample_in_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic signed [smc_pkg::SAMPLE_W-1:0] sample_out_o;

  chorus_scoreboard sb;
  bit               calm;      // no idling on either side in the closing phase
  bit               hold_req;  // asks the output side for one long hold-off

  sine_modulated_chorus_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Inputs move on the falling edge; handshakes are judged on the rising edge,
  // where the TB reads the pre-edge values of the core's registered outputs.

  // Offer one sample and hold it until the input transaction completes.
  // Entered and left on a falling edge.
  task automatic send_sample(input logic signed [15:0] v);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    sample_in_i = v;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    sb.note_sample(v);
    @(negedge clk_i);
  endtask

  // One register write per cycle; the write enable stays up across a burst.
  task automatic write_one(input logic [1:0] idx, input logic [19:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_config(input logic [19:0] wet_v, input logic [19:0] len_v,
                              input logic [19:0] step_v, input bit poke_unused);
    write_one(smc_pkg::REG_WET_PERCENT, wet_v);
    write_one(smc_pkg::REG_LINE_LENGTH, len_v);
    write_one(smc_pkg::REG_LFO_STEP, step_v);
    if (poke_unused) begin
      write_one(REG_UNUSED, 20'($urandom));
    end
    cfg_we_i = 1'b0;
  endtask

  // Stop offering and wait for every outstanding result; the core is idle after.
  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.expected_out.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Output side: random ready bursts, plus one long hold-off on request so the
  // output register and the datapath both fill and the input stalls.
  initial begin
    int unsigned hold_cycles;
    bit          hold_done;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready_i = 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 400) begin
          @(negedge clk_i);
          hold_cycles++;
        end
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
        @(negedge clk_i);
      end
    end
  end

  // Every output transaction goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_sample(sample_out_o);
    end
  end

  initial begin
    logic signed [15:0] v;
    logic [19:0]        wet_v;
    logic [19:0]        len_v;
    logic [19:0]        step_v;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    sb          = new();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: full-scale swings, zero, the smallest magnitudes.
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    send_sample(16'sh0001);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh5555);
    settle();

    // Length above the line size (clamps to full), all dry, frozen oscillator.
    apply_config(20'd0, 20'hFFF, 20'd0, 1'b0);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    settle();

    // Wet share above 100, length below 2 (write pointer past the line),
    // fastest oscillator, upper data bits set, and a write to the unmapped index.
    apply_config(20'hFFFFF, 20'hFF001, 20'hFFFFF, 1'b1);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    settle();

    // All wet on a three-entry line, a sixty-fourth of a turn per sample.
    apply_config(20'd100, 20'd3, 20'h40000, 1'b0);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh2AAA);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    settle();

    // Random phases, each under fresh settings; phase 3 carries the long
    // output hold-off, phase 7 runs with no idling at all.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        calm = 1'b1;
      end
      case ($urandom_range(0, 4))
        0:       wet_v = 20'd0;
        1:       wet_v = 20'd100;
        2:       wet_v = 20'($urandom_range(101, 127));
        3:       wet_v = 20'($urandom_range(0, 100));
        default: wet_v = 20'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       len_v = 20'd2;
        1:       len_v = 20'd2048;
        2:       len_v = 20'($urandom_range(2, 2048));
        3:       len_v = 20'($urandom_range(0, 4095));
        4:       len_v = 20'($urandom_range(2, 40));
        default: len_v = 20'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       step_v = 20'd0;
        1:       step_v = 20'hFFFFF;
        2:       step_v = 20'($urandom_range(0, 4095));
        default: step_v = 20'($urandom);
      endcase
      apply_config(wet_v, len_v, step_v, ph % 3 == 0);
      if (ph == 3) begin
        hold_req = 1'b1;
      end
      repeat (87) begin
        case ($urandom_range(0, 7))
          0: begin
            case ($urandom_range(0, 3))
              0:       v = 16'sh7FFF;
              1:       v = 16'sh8000;
              2:       v = 16'sh0000;
              default: v = 16'shFFFF;
            endcase
          end
          1:       v = 16'($signed($urandom_range(0, 600)) - 300);
          default: v = 16'($urandom);
        endcase
        send_sample(v);
      end
      settle();
    end

    // Anything arriving now would be an unrequested result.
    repeat (100) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_out.size() == 0) begin
      $display("** sine_modulated_chorus_core: PASSED **");
    end else begin
      $display("** sine_modulated_chorus_core: FAILED **");
    end
    $finish;
  end

  // Watchdog: a correct run needs about a seventh of this.
  initial begin
    #3_000_000;
    $display("** sine_modulated_chorus_core: FAILED **");
    $finish;
  end

endmodule
